// File: hdl/i2ctrf_pkg.sv
package i2ctrf_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 9;
    localparam int CNT_W  = 32;

    // event codes on the operation field
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REGISTER_COUNT = 2'd0,
        CFG_WRITE_FIRST    = 2'd1,
        CFG_WRITE_COUNT    = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

    // start request to the modulo unit
    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } t_mod_req;

endpackage

// File: hdl/i2c_target_register_file.sv
// Channel   | Valid       | Stall       | Payload
// ----------+-------------+-------------+------------------------------------------
// request   | i_in_valid  | o_in_stall  | i_operation, i_data_byte
// result    | o_out_valid | i_out_stall | o_read_data, o_byte_stored, o_pointer_now,
//           |             |             | o_writes_total, o_reads_total
//
// A write or read request goes from accept through a decode state (S_EXEC), the
// bit-serial modulo unit (S_MOD, one quotient bit per cycle over the 9-bit
// dividend) and S_FIN, which loads the result register. STOP and the unused
// code go from S_EXEC to S_FIN. Reset is synchronous and active low;
// the store reads as zero after reset through per-entry valid bits, no sweep.
// A stalled result holds the finished request in the last state; a new
// request is taken while the previous result still waits.
module i2c_target_register_file #(
    parameter int STORE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_byte_stored,
    output logic [7:0]  o_pointer_now,
    output logic [31:0] o_writes_total,
    output logic [31:0] o_reads_total,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import i2ctrf_pkg::*;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(STORE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MOD  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [CFG_W-1:0] r_reg_count;
    logic [CFG_W-1:0] r_win_first;
    logic [CFG_W-1:0] r_win_count;

    // block state
    logic [BYTE_W-1:0] r_ptr;
    logic              r_await_ptr;
    logic [CNT_W-1:0]  r_wcnt;
    logic [CNT_W-1:0]  r_rcnt;

    // request being worked on
    t_op               r_op;
    logic [BYTE_W-1:0] r_byte;
    logic              r_capture;   // this write sets the pointer
    logic              r_stored;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_rdata;
    logic              r_out_stored;
    logic [BYTE_W-1:0] r_out_ptr;
    logic [CNT_W-1:0]  r_out_wcnt;
    logic [CNT_W-1:0]  r_out_rcnt;

    logic              in_acc;
    logic              out_free;
    logic [CFG_W-1:0]  eff_count;
    logic [CFG_W:0]    ptr_x;
    logic [CFG_W:0]    ptr_rel;
    logic              in_window;
    logic [CFG_W-1:0]  ptr_inc;
    t_mod_req          mod_req;
    logic              mod_done;
    logic [CFG_W-1:0]  mod_rem;
    logic              st_wr_en;
    logic              st_rd_en;
    logic [BYTE_W-1:0] st_rd_data;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // register count: zero acts as one, above the store acts as the store depth
    always_comb begin
        if (r_reg_count == '0) begin
            eff_count = CFG_W'(1);
        end else if (r_reg_count > DEPTH_C) begin
            eff_count = DEPTH_C;
        end else begin
            eff_count = r_reg_count;
        end
    end

    // write window: first <= ptr < first + count
    assign ptr_x     = {2'b00, r_ptr};
    assign ptr_rel   = ptr_x - {1'b0, r_win_first};
    assign in_window = (ptr_x >= {1'b0, r_win_first}) && (ptr_rel < {1'b0, r_win_count});
    assign ptr_inc   = {1'b0, r_ptr} + CFG_W'(1);

    // decode cycle drives the store and starts the modulo unit for writes and reads
    always_comb begin
        mod_req  = '0;
        st_wr_en = 1'b0;
        st_rd_en = 1'b0;
        mod_req.divisor = eff_count;
        if (r_state == S_EXEC) begin
            case (r_op)
                OP_WRITE: begin
                    mod_req.start = 1'b1;
                    if (r_await_ptr) begin
                        mod_req.dividend = {1'b0, r_byte};
                    end else begin
                        mod_req.dividend = ptr_inc;
                        st_wr_en         = in_window;
                    end
                end
                OP_READ: begin
                    mod_req.start    = 1'b1;
                    mod_req.dividend = ptr_inc;
                    st_rd_en         = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    i2ctrf_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    i2ctrf_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (st_wr_en),
        .i_rd_en   (st_rd_en),
        .i_addr    (r_ptr[ADDR_W-1:0]),
        .i_wr_data (r_byte),
        .o_rd_data (st_rd_data)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= CFG_W'(256);
            r_win_first <= '0;
            r_win_count <= CFG_W'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REGISTER_COUNT: r_reg_count <= i_cfg_data;
                CFG_WRITE_FIRST:    r_win_first <= i_cfg_data;
                CFG_WRITE_COUNT:    r_win_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_await_ptr <= 1'b1;
            r_wcnt      <= '0;
            r_rcnt      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_WRITE: begin
                            r_state <= S_MOD;
                            if (!r_await_ptr) begin
                                r_wcnt <= r_wcnt + 1'b1;
                            end
                        end
                        OP_READ: begin
                            r_state <= S_MOD;
                            r_rcnt  <= r_rcnt + 1'b1;
                        end
                        OP_STOP: begin
                            r_state     <= S_FIN;
                            r_await_ptr <= 1'b1;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_state <= S_FIN;
                        r_ptr   <= mod_rem[BYTE_W-1:0];
                        if (r_capture) begin
                            r_await_ptr <= 1'b0;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result valid: set when a finished request loads, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= t_op'(i_operation);
            r_byte <= i_data_byte;
        end
        if (r_state == S_EXEC) begin
            r_capture <= (r_op == OP_WRITE) && r_await_ptr;
            r_stored  <= st_wr_en;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_rdata  <= (r_op == OP_READ) ? st_rd_data : 8'd0;
            r_out_stored <= r_stored && (r_op == OP_WRITE);
            r_out_ptr    <= r_ptr;
            r_out_wcnt   <= r_wcnt;
            r_out_rcnt   <= r_rcnt;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rdata;
    assign o_byte_stored  = r_out_stored;
    assign o_pointer_now  = r_out_ptr;
    assign o_writes_total = r_out_wcnt;
    assign o_reads_total  = r_out_rcnt;

endmodule

// File: hdl/i2ctrf_mod_unit.sv
module i2ctrf_mod_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2ctrf_pkg::t_mod_req  i_req,
    output logic                  o_done,
    output logic [8:0]            o_rem
);
    import i2ctrf_pkg::*;

    localparam int STEP_W = $clog2(CFG_W + 1);

    logic                r_busy;
    logic [STEP_W-1:0]   r_cnt;
    logic [CFG_W-1:0]    r_rem;
    logic [CFG_W-1:0]    r_dvd;
    logic [CFG_W-1:0]    r_dvs;
    logic [CFG_W:0]      n_trial;
    logic [CFG_W:0]      n_diff;
    logic [CFG_W-1:0]    n_rem;

    // restoring step: bring in one dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_dvd[CFG_W-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_rem = n_diff[CFG_W-1:0];
        end else begin
            n_rem = n_trial[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(CFG_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[CFG_W-2:0], 1'b0};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

// File: hdl/i2ctrf_store.sv
module i2ctrf_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [7:0]        i_wr_data,
    output logic [7:0]        o_rd_data
);
    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_mem;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_mem <= r_mem[i_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_mem : 8'd0;

endmodule

// File: hdl/i2ctrf_checker.sv
module i2ctrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_read_data,
    input logic        o_byte_stored,
    input logic [7:0]  o_pointer_now,
    input logic [31:0] o_writes_total
);
    // nothing pending right after reset
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or busy after reset");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // a stored write never returns read data
    a_store_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_stored |-> o_read_data == 8'd0)
        else $error("read data on a stored write");

    // stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pointer_now) && $stable(o_writes_total))
        else $error("stalled result changed");

endmodule

bind i2c_target_register_file i2ctrf_checker u_i2ctrf_checker (.*);
